// ===== design/xorshift_bounded_random_range_macros.svh =====
// Assertion macros used by the range generator datapath.
`ifndef XORSHIFT_BOUNDED_RANDOM_RANGE_MACROS_SVH
`define XORSHIFT_BOUNDED_RANDOM_RANGE_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication or a plain property on every rising clock edge out of reset.
`define XBR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("xbr assertion failed");

// Check that a condition never holds out of reset.
`define XBR_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("xbr forbidden condition seen");

`else

`define XBR_ASSERT(lbl, clk, rstn, prop)
`define XBR_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== design/xbr_pkg.sv =====
package xbr_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned CNT_W  = 5;

	localparam logic [DATA_W-1:0] SEED_RESET = 32'h0000_0001;
	localparam logic [DATA_W-1:0] DRAW_MAX   = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] SIGN_FLIP  = 32'h8000_0000;
	localparam logic [CNT_W-1:0]  DIV_LAST   = 5'd31;

	// Register index as decoded from paddr[2]
	localparam logic REG_SEED = 1'b0;

	typedef enum logic [1:0] {
		RES_BAD,
		RES_RAW,
		RES_DIV
	} res_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_B,
		ST_LIMIT,
		ST_DRAW,
		ST_TEST,
		ST_DIV_R,
		ST_DONE_BAD,
		ST_DONE_RAW,
		ST_DONE_DIV
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     step_gen;
		logic     div_start_span;
		logic     div_start_draw;
		logic     latch_limit;
		logic     out_load;
		res_sel_t out_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic bad;
		logic span_zero;
		logic div_busy;
		logic draw_ok;
		logic out_free;
	} dp_sts_t;

	// One xorshift32 step
	function automatic logic [DATA_W-1:0] xorshift(input logic [DATA_W-1:0] x);
		logic [DATA_W-1:0] s;
		s = x;
		s = s ^ (s << 13);
		s = s ^ (s >> 17);
		s = s ^ (s << 5);
		return s;
	endfunction

endpackage

// ===== design/xbr_ctrl.sv =====
module xbr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  xbr_pkg::dp_sts_t  sts,
	output xbr_pkg::dp_cmd_t  cmd
);

	xbr_pkg::state_t state_q;
	xbr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xbr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d            = state_q;
		in_ready           = 1'b0;
		cmd.load_in        = 1'b0;
		cmd.step_gen       = 1'b0;
		cmd.div_start_span = 1'b0;
		cmd.div_start_draw = 1'b0;
		cmd.latch_limit    = 1'b0;
		cmd.out_load       = 1'b0;
		cmd.out_sel        = xbr_pkg::RES_DIV;
		case (state_q)
			xbr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = xbr_pkg::ST_CHECK;
				end
			end
			xbr_pkg::ST_CHECK: begin
				if (sts.bad) begin
					state_d = xbr_pkg::ST_DONE_BAD;
				end else if (sts.span_zero) begin
					cmd.step_gen = 1'b1;
					state_d      = xbr_pkg::ST_DONE_RAW;
				end else begin
					cmd.div_start_span = 1'b1;
					state_d            = xbr_pkg::ST_DIV_B;
				end
			end
			xbr_pkg::ST_DIV_B: begin
				if (!sts.div_busy) begin
					state_d = xbr_pkg::ST_LIMIT;
				end
			end
			xbr_pkg::ST_LIMIT: begin
				cmd.latch_limit = 1'b1;
				state_d         = xbr_pkg::ST_DRAW;
			end
			xbr_pkg::ST_DRAW: begin
				cmd.step_gen = 1'b1;
				state_d      = xbr_pkg::ST_TEST;
			end
			xbr_pkg::ST_TEST: begin
				// redraw in place until the draw falls below the limit
				if (sts.draw_ok) begin
					cmd.div_start_draw = 1'b1;
					state_d            = xbr_pkg::ST_DIV_R;
				end else begin
					cmd.step_gen = 1'b1;
				end
			end
			xbr_pkg::ST_DIV_R: begin
				if (!sts.div_busy) begin
					state_d = xbr_pkg::ST_DONE_DIV;
				end
			end
			xbr_pkg::ST_DONE_BAD: begin
				cmd.out_sel = xbr_pkg::RES_BAD;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = xbr_pkg::ST_IDLE;
				end
			end
			xbr_pkg::ST_DONE_RAW: begin
				cmd.out_sel = xbr_pkg::RES_RAW;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = xbr_pkg::ST_IDLE;
				end
			end
			xbr_pkg::ST_DONE_DIV: begin
				cmd.out_sel = xbr_pkg::RES_DIV;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = xbr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = xbr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/xbr_dp.sv =====
`include "xorshift_bounded_random_range_macros.svh"

module xbr_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  xbr_pkg::dp_cmd_t           cmd,
	output xbr_pkg::dp_sts_t           sts,
	input  logic [xbr_pkg::DATA_W-1:0] in_lower,
	input  logic [xbr_pkg::DATA_W-1:0] in_upper,
	input  logic                       seed_load,
	input  logic [xbr_pkg::DATA_W-1:0] seed_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [xbr_pkg::DATA_W-1:0] out_value,
	output logic                       out_bad
);

	localparam int unsigned W = xbr_pkg::DATA_W;

	logic [W-1:0] lo_q, hi_q, span_q, gen_q, limit_q, buckets_q;
	logic [W-1:0] rem_q, quo_q, dvs_q;
	logic [xbr_pkg::CNT_W-1:0] cnt_q;
	logic         busy_q;
	logic [W-1:0] value_q;
	logic         bad_q, out_valid_q;
	logic [W-1:0] span_c, res_c;
	logic [W:0]   trial_c;
	logic [W:0]   shifted_c;

	assign span_c = hi_q - lo_q + {{(W-1){1'b0}}, 1'b1};

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			lo_q <= in_lower;
			hi_q <= in_upper;
		end
		span_q <= span_c;
		if (cmd.latch_limit) begin
			buckets_q <= quo_q;
			limit_q   <= quo_q * span_q;
		end
	end

	// Generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= xbr_pkg::SEED_RESET;
		end else if (seed_load) begin
			gen_q <= seed_value;
		end else if (cmd.step_gen) begin
			gen_q <= xbr_pkg::xorshift(gen_q);
		end
	end

	// Restoring divider, one quotient bit per cycle
	assign shifted_c = {rem_q, quo_q[W-1]};
	assign trial_c   = shifted_c - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.div_start_span || cmd.div_start_draw) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + {{(xbr_pkg::CNT_W-1){1'b0}}, 1'b1};
			if (cnt_q == xbr_pkg::DIV_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start_span) begin
			rem_q <= '0;
			quo_q <= xbr_pkg::DRAW_MAX;
			dvs_q <= span_c;
		end else if (cmd.div_start_draw) begin
			rem_q <= '0;
			quo_q <= gen_q;
			dvs_q <= buckets_q;
		end else if (busy_q) begin
			if (!trial_c[W]) begin
				rem_q <= trial_c[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted_c[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		case (cmd.out_sel)
			xbr_pkg::RES_BAD: res_c = lo_q;
			xbr_pkg::RES_RAW: res_c = gen_q + lo_q;
			xbr_pkg::RES_DIV: res_c = quo_q + lo_q;
			default:          res_c = lo_q;
		endcase
	end

	// Output register: holds one result while the next item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_q <= res_c;
			bad_q   <= (cmd.out_sel == xbr_pkg::RES_BAD);
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = value_q;
	assign out_bad   = bad_q;

	assign sts.bad       = (hi_q ^ xbr_pkg::SIGN_FLIP) < (lo_q ^ xbr_pkg::SIGN_FLIP);
	assign sts.span_zero = (span_c == '0);
	assign sts.div_busy  = busy_q;
	assign sts.draw_ok   = gen_q < limit_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	`XBR_NEVER(a_start_busy, clk, arst_n, (cmd.div_start_span || cmd.div_start_draw) && busy_q)
	`XBR_ASSERT(a_draw_below, clk, arst_n, cmd.div_start_draw |-> gen_q < limit_q)
	`XBR_ASSERT(a_load_free, clk, arst_n, cmd.out_load |-> (!out_valid_q || out_ready))
	`XBR_ASSERT(a_div_nonzero, clk, arst_n, $rose(busy_q) |-> dvs_q != '0)

endmodule

// ===== design/xorshift_bounded_random_range.sv =====
// Sequence: bad bounds or the full span go from the check straight to the output; other requests
// pass the span division, limit, draw loop (one redraw per rejected draw) and draw division,
// both on the shared bit-serial divider. One item at a time: a new request is taken once the
// previous one has left the controller.
// Reset (arst_n, asynchronous, active low): generator state and seed go to 1, the
// controller returns to idle and no result is pending.
module xorshift_bounded_random_range (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [xbr_pkg::ADDR_W-1:0]  paddr,
	input  logic [xbr_pkg::DATA_W-1:0]  pwdata,
	output logic [xbr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// request stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [2*xbr_pkg::DATA_W-1:0] s_tdata,  // [31:0] lower_bound, [63:32] upper_bound
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [xbr_pkg::DATA_W-1:0]  m_tdata,   // [31:0] value
	output logic [0:0]                  m_tuser    // [0] bad_bounds
);

	localparam int unsigned W = xbr_pkg::DATA_W;

	xbr_pkg::dp_cmd_t cmd;
	xbr_pkg::dp_sts_t sts;

	logic         seed_wr;
	logic [W-1:0] seed_q;

	// The register file has a single entry; paddr[2] selects the register index, so
	// a write to any address of a higher index is dropped.
	assign pready  = 1'b1;
	assign seed_wr = psel && penable && pwrite && pready && (paddr[2] == xbr_pkg::REG_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= xbr_pkg::SEED_RESET;
		end else if (seed_wr) begin
			seed_q <= pwdata;
		end
	end

	// Read back the seed; other addresses read as zero
	assign prdata = (paddr[2] == xbr_pkg::REG_SEED) ? seed_q : '0;

	// Controller: sequences check, span division, limit, draw loop, draw division and
	// the output transfer
	xbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: generator, shared divider, limit multiply and output register. A seed
	// write reloads the generator state directly.
	xbr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_lower   (s_tdata[W-1:0]),
		.in_upper   (s_tdata[2*W-1:W]),
		.seed_load  (seed_wr),
		.seed_value (pwdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_bad    (m_tuser[0])
	);

endmodule

// ===== tb/sv/testbench.sv =====
// Checks the bounded xorshift range generator against a cycle-free predictor.
// Requests go in over the s_ stream, results come out over the m_ stream, and
// the seed register is reached over the APB port. Every accepted request is
// predicted right away, and each result transfer is compared with the oldest
// prediction.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ADDR_W = xbr_pkg::ADDR_W;
	localparam logic [31:0] SEED_RESET = xbr_pkg::SEED_RESET;

	// Register indexes and their byte addresses. Index 1 decodes to nothing.
	localparam int unsigned SEED_INDEX   = 0;
	localparam int unsigned UNUSED_INDEX = 1;
	localparam logic [ADDR_W-1:0] SEED_ADDR   = ADDR_W'(4 * SEED_INDEX);
	localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4 * UNUSED_INDEX);

	localparam logic [31:0] INT_MIN  = 32'h8000_0000;
	localparam logic [31:0] INT_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	// Cycles to let pass after the last result before touching the register.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int SEED_PHASES   = 6;

	typedef struct {
		logic [31:0] value;
		logic        bad_bounds;
	} range_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;  // [31:0] lower_bound, [63:32] upper_bound
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;       // [31:0] value
	logic [0:0]  m_tuser;       // [0] bad_bounds

	// Predictor state: generator and seed shadow.
	logic [31:0] xs_state;
	logic [31:0] seed_shadow;
	range_result_t pending_results[$];

	// Throttle controls: no_gaps for the sender and the result sink, sink_hold for the sink alone.
	bit no_gaps = 1'b0;
	int sink_hold = 0;

	int mismatches = 0;
	int n_requests = 0;
	int n_results = 0;
	int n_bad = 0;
	int n_full = 0;
	int n_rejects = 0;
	int n_seed_writes = 0;

	xorshift_bounded_random_range dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Advance the generator one xorshift step and return the new draw.
	function automatic logic [31:0] next_draw();
		logic [31:0] x;
		x = xs_state;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		xs_state = x;
		return x;
	endfunction

	// Work out the result of one request and advance the generator as the
	// block should. Rejected draws are counted for the summary.
	function automatic range_result_t draw_in_range(input logic [31:0] lo,
			input logic [31:0] hi);
		range_result_t r;
		logic [31:0] span;
		logic [31:0] buckets;
		logic [31:0] limit;
		logic [31:0] draw;
		r.bad_bounds = 1'b0;
		// Upper below lower: flag it, hand back the lower bound, leave the state.
		if ($signed(hi) < $signed(lo)) begin
			r.value = lo;
			r.bad_bounds = 1'b1;
			n_bad++;
			return r;
		end
		span = hi - lo + 32'd1;
		// Full span wraps the width to zero: one raw draw, offset by lower.
		if (span == 32'd0) begin
			r.value = next_draw() + lo;
			n_full++;
			return r;
		end
		buckets = ALL_ONES / span;
		limit = buckets * span;
		draw = next_draw();
		while (draw >= limit) begin
			n_rejects++;
			draw = next_draw();
		end
		r.value = draw / buckets + lo;
		return r;
	endfunction

	// Mirror a register write; an index outside the map changes nothing.
	function automatic void apply_register_write(input int unsigned index,
			input logic [31:0] data);
		if (index == SEED_INDEX) begin
			seed_shadow = data;
			xs_state = data;
		end
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	// Compare every result transfer with the oldest outstanding prediction.
	always @(posedge clk) begin : result_check
		range_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result, value", 32'hx, m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.value)
					note_mismatch("value", want.value, m_tdata);
				if (m_tuser[0] !== want.bad_bounds)
					note_mismatch("bad_bounds", 32'(want.bad_bounds), 32'(m_tuser[0]));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// Mostly short gaps, now and then a long one; none while no_gaps is set.
	function automatic int pick_gap();
		int roll;
		if (no_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	// Result sink: drop tready for random stretches, and while sink_hold counts down
	// after it is loaded.
	initial begin : result_sink
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				sink_hold--;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	// Offer one request and hold it until the transfer; predict at the transfer.
	// Valid stays high afterwards, so back-to-back requests do not drop it in between.
	task automatic send_bounds(input logic [31:0] lo, input logic [31:0] hi);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {hi, lo};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(draw_in_range(lo, hi));
		n_requests++;
	endtask

	// Drop valid, wait for every outstanding result, then let the block settle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready, then back to idle.
	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_register_write(addr >> 2, data);
		n_seed_writes += (addr >> 2) == SEED_INDEX;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// APB read of the seed register, checked against the shadow.
	task automatic check_seed_readback();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= SEED_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== seed_shadow)
			note_mismatch("seed readback", seed_shadow, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Change the seed between phases, only once the block has gone quiet.
	task automatic reseed(input logic [31:0] seed);
		drain_results();
		reg_write(SEED_ADDR, seed);
		check_seed_readback();
	endtask

	// Random request mix: wide random pairs (about half with bounds swapped),
	// narrow and tiny spans, spans near powers of two, near-full and full
	// spans, equal bounds and more swapped bounds.
	task automatic pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
		logic [31:0] span;
		int k;
		case ($urandom_range(0, 9))
			0, 1: begin
				lo = $urandom;
				hi = $urandom;
			end
			2, 3: begin
				lo = $urandom;
				hi = lo + $urandom_range(0, 15);
				if ($signed(hi) < $signed(lo))
					hi = INT_MAX;
			end
			4, 5: begin
				lo = 32'($urandom_range(0, 2000)) - 32'd1000;
				hi = lo + $urandom_range(0, 1000);
			end
			6: begin
				lo = INT_MIN + $urandom_range(0, 1000);
				hi = INT_MAX - $urandom_range(0, 1000);
			end
			7: begin
				k = $urandom_range(0, 31);
				span = (32'd1 << k) + $urandom_range(0, 2) - 32'd1;
				lo = 32'd0 - (span >> 1);
				hi = lo + span - 32'd1;
			end
			8: begin
				lo = $urandom;
				hi = lo;
			end
			default: begin
				if ($urandom_range(0, 1) == 0) begin
					lo = INT_MIN;
					hi = INT_MAX;
				end else begin
					lo = $urandom;
					hi = lo - 32'd1 - $urandom_range(0, 100);
				end
			end
		endcase
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Seed comes out of reset at 1; run a few requests on it.
	task automatic test_reset_seed();
		check_seed_readback();
		send_bounds(32'd0, 32'd9);
		send_bounds(32'hFFFF_FF00, 32'd255);
		send_bounds(32'd1, 32'd1);
	endtask

	// Extremes of both bounds, swapped bounds, full span and heavy rejection.
	task automatic test_bound_extremes();
		send_bounds(32'd0, 32'd0);
		send_bounds(INT_MIN, INT_MIN);
		send_bounds(INT_MAX, INT_MAX);
		send_bounds(INT_MIN, INT_MAX);      // width wraps to zero
		send_bounds(INT_MIN, INT_MAX);
		send_bounds(INT_MIN, 32'd0);        // width 2^31 + 1: about half the draws rejected
		send_bounds(32'hC000_0000, 32'h4000_0000);
		send_bounds(32'd0, INT_MAX);
		send_bounds(ALL_ONES, 32'd0);
		send_bounds(INT_MAX, INT_MIN);      // upper below lower
		send_bounds(32'd1, 32'd0);
		send_bounds(32'd0, ALL_ONES);
		send_bounds(INT_MIN + 32'd1, INT_MIN);
		send_bounds(ALL_ONES, ALL_ONES);
		send_bounds(32'hFFFF_FFFB, 32'd5);
		send_bounds(INT_MIN + 32'd1, INT_MAX);
		send_bounds(INT_MIN, INT_MAX - 32'd1);
		send_bounds(32'h5555_5555, 32'h2AAA_AAAA);
		send_bounds(32'hAAAA_AAAA, 32'h5555_5555);
	endtask

	// Seed extremes, a zero seed that freezes the generator, and a write to an
	// address outside the map that must leave the seed alone.
	task automatic test_seed_writes();
		reseed(ALL_ONES);
		send_bounds(32'd0, 32'd99);
		send_bounds(INT_MIN, INT_MAX);
		reseed(INT_MIN);
		send_bounds(32'hFFFF_FFF0, 32'd16);
		send_bounds(INT_MIN, 32'd0);
		// Zero seed: every draw is zero, the result is the lower bound.
		reseed(32'd0);
		send_bounds(32'd10, 32'd20);
		send_bounds(INT_MIN, INT_MAX);
		send_bounds(32'hFFFF_FF9C, 32'd0);
		reseed(32'h1234_5678);
		drain_results();
		reg_write(UNUSED_ADDR, 32'hDEAD_BEEF);
		check_seed_readback();
		send_bounds(32'd0, 32'd1000);
		send_bounds(32'd7, 32'd3);
		reseed(SEED_RESET);
		send_bounds(32'd0, 32'd1);
	endtask

	// Hold the sink off for a long stretch while requests keep coming, so the
	// result register fills and the block backs up into the request side.
	task automatic test_backpressure();
		drain_results();
		no_gaps = 1'b1;
		sink_hold = 600;
		repeat (12) begin
			send_bounds(32'($urandom_range(0, 50)) - 32'd25, 32'd25 + $urandom_range(0, 50));
		end
		no_gaps = 1'b0;
		drain_results();
	endtask

	// Long random run split into seed phases, with stretches free of idling.
	task automatic test_random_requests();
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] seed;
		int per_phase;
		per_phase = RANDOM_ITEMS / SEED_PHASES;
		for (int p = 0; p < SEED_PHASES; p++) begin
			if (p > 0) begin
				seed = $urandom;
				if (p == SEED_PHASES - 1)
					seed = ALL_ONES;
				else if (seed == 32'd0)
					seed = SEED_RESET;
				reseed(seed);
			end
			for (int i = 0; i < per_phase; i++) begin
				if (i % 50 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				pick_bounds(lo, hi);
				send_bounds(lo, hi);
			end
		end
		no_gaps = 1'b0;
		drain_results();
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------

	initial begin : main
		xs_state = SEED_RESET;
		seed_shadow = SEED_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_seed();
		test_bound_extremes();
		test_seed_writes();
		test_backpressure();
		test_random_requests();
		drain_results();

		$display("Covered %0d requests: %0d with swapped bounds, %0d full-width, %0d rejected draws.",
			n_requests, n_bad, n_full, n_rejects);
		$display("Checked %0d results across %0d seed loads, %0d mismatches.",
			n_results, n_seed_writes, mismatches);
		if (mismatches == 0)
			$display("xorshift_bounded_random_range verification clean");
		else
			$display("xorshift_bounded_random_range verification failed");
		$finish;
	end

	// Timeout: stop the run if the main sequence has not finished.
	initial begin : watchdog
		#10_000_000;
		$display("Timeout with %0d results still outstanding.", pending_results.size());
		$display("xorshift_bounded_random_range verification failed");
		$finish;
	end

endmodule
